FILE: design/tcb_pkg.sv
// Shared types and constants of the triangle coverage block.
`default_nettype none

package tcb_pkg;

    typedef logic signed [15:0] coord_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_EDGE_THRESHOLD = 2'd2;

    // Register reset values.
    localparam logic [12:0] RST_IMAGE_WIDTH    = 13'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT   = 13'd480;
    localparam logic [11:0] RST_EDGE_THRESHOLD = 12'd20;

    // Saturation limits of a 16-bit weight.
    localparam coord_t COORD_MAX = 16'sh7FFF;
    localparam coord_t COORD_MIN = 16'sh8000;

    // Quotient bits of the weight divider: bit 16 flags overflow.
    localparam int WQ_BITS = 17;

    // Widths of the cross products and numerators.
    localparam int DEN_BITS = 35;
    localparam int NUM_BITS = 37;

endpackage

`default_nettype wire

FILE: design/tcb_delay.sv
// Enable-gated delay line with reset, used to align side data with the pipeline.
`default_nettype none

module tcb_delay
    import tcb_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

`default_nettype wire

FILE: design/tcb_pixdiv.sv
// Pipelined pixel-to-normalized-space mapping: one quotient bit per stage.
`default_nettype none

module tcb_pixdiv
    import tcb_pkg::*;
#(
    parameter int F  = 12,
    parameter int PB = 12
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [PB-1:0] pix,
    input  logic [12:0]   size,
    output coord_t        p
);

    localparam int NQ = PB + 1 + F;
    localparam int RW = NQ + 13;
    localparam int XW = NQ + 18;
    localparam logic signed [XW-1:0] ONE_X = XW'(1) << F;
    localparam logic signed [XW-1:0] MAX_X = XW'(32767);
    localparam logic signed [XW-1:0] MIN_X = -(XW'(32768));

    logic [RW-1:0] r_reg [0:NQ];
    logic [NQ-1:0] q_reg [0:NQ];
    logic [12:0]   sz;
    logic signed [XW-1:0] diff;
    coord_t        p_reg;

    // A size of zero is taken as one.
    assign sz = (size == 13'd0) ? 13'd1 : size;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= RW'({pix, 1'b0}) << F;
            q_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < NQ; i++)
    begin : g_stage
        localparam int K = NQ - 1 - i;
        logic [RW-1:0] dsh;
        assign dsh = RW'(sz) << K;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (r_reg[i] >= dsh)
                begin
                    r_reg[i+1] <= r_reg[i] - dsh;
                    q_reg[i+1] <= q_reg[i] | (NQ'(1) << K);
                end
                else
                begin
                    r_reg[i+1] <= r_reg[i];
                    q_reg[i+1] <= q_reg[i];
                end
            end
        end
    end

    assign diff = $signed(XW'(q_reg[NQ])) - ONE_X;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (diff > MAX_X)
            begin
                p_reg <= COORD_MAX;
            end
            else if (diff < MIN_X)
            begin
                p_reg <= COORD_MIN;
            end
            else
            begin
                p_reg <= diff[15:0];
            end
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

FILE: design/tcb_wdiv.sv
// Pipelined weight divider: saturated floor(num * 2^F / den) for den > 0.
`default_nettype none

module tcb_wdiv
    import tcb_pkg::*;
#(
    parameter int F = 12
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0]        den,
    output coord_t                     w
);

    localparam int RW = NUM_BITS + F + WQ_BITS;

    logic [RW-1:0]       m_reg [0:WQ_BITS];
    logic [DEN_BITS-1:0] d_reg [0:WQ_BITS];
    logic [WQ_BITS-1:0]  q_reg [0:WQ_BITS];
    logic                n_reg [0:WQ_BITS];
    logic [NUM_BITS-1:0] mag;
    logic [WQ_BITS-1:0]  qf;
    logic [WQ_BITS-1:0]  qup;
    logic                rnz;
    coord_t              w_next;
    coord_t              w_reg;

    assign mag = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= RW'(mag) << F;
            d_reg[0] <= den;
            q_reg[0] <= '0;
            n_reg[0] <= num[NUM_BITS-1];
        end
    end

    for (genvar i = 0; i < WQ_BITS; i++)
    begin : g_stage
        localparam int K = WQ_BITS - 1 - i;
        logic [RW-1:0] dsh;
        assign dsh = RW'(d_reg[i]) << K;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[i+1] <= d_reg[i];
                n_reg[i+1] <= n_reg[i];
                if (m_reg[i] >= dsh)
                begin
                    m_reg[i+1] <= m_reg[i] - dsh;
                    q_reg[i+1] <= q_reg[i] | (WQ_BITS'(1) << K);
                end
                else
                begin
                    m_reg[i+1] <= m_reg[i];
                    q_reg[i+1] <= q_reg[i];
                end
            end
        end
    end

    // The top quotient bit means the magnitude is at least 2^16.
    assign qf  = q_reg[WQ_BITS];
    assign rnz = |m_reg[WQ_BITS];
    assign qup = qf + WQ_BITS'(rnz);

    always_comb
    begin
        if (!n_reg[WQ_BITS])
        begin
            if (qf[16] || qf[15])
            begin
                w_next = COORD_MAX;
            end
            else
            begin
                w_next = qf[15:0];
            end
        end
        else
        begin
            // A negative quotient rounds away from zero when a remainder is left.
            if (qf[16] || (qup > WQ_BITS'(32768)))
            begin
                w_next = COORD_MIN;
            end
            else
            begin
                w_next = 16'(-qup);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg <= w_next;
        end
    end

    assign w = w_reg;

endmodule

`default_nettype wire

FILE: design/triangle_coverage_barycentric.sv
// Top level of the barycentric triangle coverage test pipeline.
//
// One item on the input channel carries a triangle's three vertices (signed
// fixed point with COORD_FRAC_BITS fraction bits) and one pixel position. The
// result item gives the barycentric weights u, v and w, the coverage flag and
// the degenerate flag. Both channels use valid and stall; an item moves when
// valid is high and stall is low.
//
// The pipeline takes a new item every cycle while the result is not stalled. In
// order, the pixel mapping dividers form their quotients bit by bit, five stages
// form the edge differences, cross products and numerators, and the weight
// dividers form their quotients bit by bit plus entry and saturation stages.
//
// When the receiver stalls a valid result, the whole pipeline holds and the
// input channel shows stall in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads the image size and threshold
// registers with 640, 480 and 20. The configuration port is always ready; the
// user must write it only while the pipeline is empty, as the block does not enforce this.
`default_nettype none

module triangle_coverage_barycentric
    import tcb_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 12,
    parameter int PIXEL_BITS      = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [15:0] a_x,
    input  logic signed [15:0] a_y,
    input  logic signed [15:0] b_x,
    input  logic signed [15:0] b_y,
    input  logic signed [15:0] c_x,
    input  logic signed [15:0] c_y,
    input  logic [11:0] pixel_x,
    input  logic [11:0] pixel_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        inside_res,
    output logic signed [15:0] weight_u,
    output logic signed [15:0] weight_v,
    output logic signed [15:0] weight_w,
    output logic        degenerate,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int F   = COORD_FRAC_BITS;
    localparam int PB  = PIXEL_BITS;
    localparam int LP  = PB + 1 + F + 2;
    localparam int LW  = WQ_BITS + 2;
    localparam int LT  = LP + 5 + LW;
    localparam int CW  = NUM_BITS + F + 2;

    logic        en;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [11:0] thr_reg;

    // The pipeline moves whenever the output is not held by the receiver.
    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            thr_reg    <= RST_EDGE_THRESHOLD;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:    width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT:   height_reg <= cfg_data;
                CFG_EDGE_THRESHOLD: thr_reg    <= cfg_data[11:0];
                default:            ;
            endcase
        end
    end

    // Valid bits travel the full depth alongside the data.
    tcb_delay #(.WIDTH(1), .DEPTH(LT)) u_vld (
        .clk(clk), .rst_n(rst_n), .en(en), .din(in_valid), .dout(out_valid)
    );

    // Pixel mapping to normalized space. Only the low PIXEL_BITS bits count.
    logic [PB+11:0] pxw;
    logic [PB+11:0] pyw;
    coord_t         px;
    coord_t         py;

    assign pxw = {{PB{1'b0}}, pixel_x};
    assign pyw = {{PB{1'b0}}, pixel_y};

    tcb_pixdiv #(.F(F), .PB(PB)) u_pdx (
        .clk(clk), .en(en), .pix(pxw[PB-1:0]), .size(width_reg), .p(px)
    );

    tcb_pixdiv #(.F(F), .PB(PB)) u_pdy (
        .clk(clk), .en(en), .pix(pyw[PB-1:0]), .size(height_reg), .p(py)
    );

    // Vertices wait alongside the pixel mapping.
    logic [95:0] vtx;
    coord_t dax, day, dbx, dby, dcx, dcy;

    tcb_delay #(.WIDTH(96), .DEPTH(LP)) u_vtx (
        .clk(clk), .rst_n(rst_n), .en(en),
        .din({a_x, a_y, b_x, b_y, c_x, c_y}), .dout(vtx)
    );

    assign {dax, day, dbx, dby, dcx, dcy} = vtx;

    // Stage 1: edge vectors e0 = C - A, e1 = B - A, ep = P - A.
    logic signed [16:0] e0x_reg, e0y_reg, e1x_reg, e1y_reg, epx_reg, epy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e0x_reg <= 17'(dcx) - 17'(dax);
            e0y_reg <= 17'(dcy) - 17'(day);
            e1x_reg <= 17'(dbx) - 17'(dax);
            e1y_reg <= 17'(dby) - 17'(day);
            epx_reg <= 17'(px) - 17'(dax);
            epy_reg <= 17'(py) - 17'(day);
        end
    end

    // Stage 2: the six products of the three cross products.
    logic signed [33:0] pd0_reg, pd1_reg, pu0_reg, pu1_reg, pv0_reg, pv1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd0_reg <= e0x_reg * e1y_reg;
            pd1_reg <= e0y_reg * e1x_reg;
            pu0_reg <= epx_reg * e1y_reg;
            pu1_reg <= epy_reg * e1x_reg;
            pv0_reg <= e0x_reg * epy_reg;
            pv1_reg <= e0y_reg * epx_reg;
        end
    end

    // Stage 3: denominator and the two weight numerators.
    logic signed [DEN_BITS-1:0] den3_reg, nu3_reg, nv3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den3_reg <= DEN_BITS'(pd0_reg) - DEN_BITS'(pd1_reg);
            nu3_reg  <= DEN_BITS'(pu0_reg) - DEN_BITS'(pu1_reg);
            nv3_reg  <= DEN_BITS'(pv0_reg) - DEN_BITS'(pv1_reg);
        end
    end

    // Stage 4: flip signs so that the denominator is not negative.
    logic signed [DEN_BITS-1:0] den4_reg, nu4_reg, nv4_reg;
    logic                       dz4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dz4_reg <= (den3_reg == '0);
            if (den3_reg < 0)
            begin
                den4_reg <= -den3_reg;
                nu4_reg  <= -nu3_reg;
                nv4_reg  <= -nv3_reg;
            end
            else
            begin
                den4_reg <= den3_reg;
                nu4_reg  <= nu3_reg;
                nv4_reg  <= nv3_reg;
            end
        end
    end

    // Stage 5: the third numerator and the threshold product.
    logic signed [NUM_BITS-1:0] nu5_reg, nv5_reg, nw5_reg;
    logic [DEN_BITS-1:0]        den5_reg;
    logic [46:0]                thp5_reg;
    logic                       pos5_reg;
    logic                       dz5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nu5_reg  <= NUM_BITS'(nu4_reg);
            nv5_reg  <= NUM_BITS'(nv4_reg);
            nw5_reg  <= NUM_BITS'(den4_reg) - NUM_BITS'(nu4_reg) - NUM_BITS'(nv4_reg);
            den5_reg <= den4_reg;
            thp5_reg <= 47'(thr_reg) * 47'(den4_reg[33:0]);
            pos5_reg <= !nu4_reg[DEN_BITS-1] && !nv4_reg[DEN_BITS-1];
            dz5_reg  <= dz4_reg;
        end
    end

    // The bound u + v < 1 + threshold is rewritten as -nw * 2^F < threshold * den,
    // decided on exact numerators rather than the rounded weights.
    logic signed [CW-1:0] nw_x;
    logic signed [CW-1:0] thp_x;
    logic                 inside5;
    logic [1:0]           flags;

    assign nw_x    = CW'(nw5_reg);
    assign thp_x   = $signed(CW'(thp5_reg));
    assign inside5 = pos5_reg && ((-(nw_x <<< F)) < thp_x);

    tcb_delay #(.WIDTH(2), .DEPTH(LW)) u_flg (
        .clk(clk), .rst_n(rst_n), .en(en),
        .din({inside5, dz5_reg}), .dout(flags)
    );

    coord_t wu, wv, ww;

    tcb_wdiv #(.F(F)) u_divu (
        .clk(clk), .en(en), .num(nu5_reg), .den(den5_reg), .w(wu)
    );

    tcb_wdiv #(.F(F)) u_divv (
        .clk(clk), .en(en), .num(nv5_reg), .den(den5_reg), .w(wv)
    );

    tcb_wdiv #(.F(F)) u_divw (
        .clk(clk), .en(en), .num(nw5_reg), .den(den5_reg), .w(ww)
    );

    // A degenerate triangle reports outside with all weights zero.
    assign degenerate = flags[0];
    assign inside_res = flags[1] && !flags[0];
    assign weight_u   = flags[0] ? '0 : wu;
    assign weight_v   = flags[0] ? '0 : wv;
    assign weight_w   = flags[0] ? '0 : ww;

endmodule

`default_nettype wire

FILE: design/tcb_checker.sv
// Port-level checks of the triangle coverage block and their binding.
`default_nettype none

module tcb_checker
    import tcb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        inside_res,
    input logic signed [15:0] weight_u,
    input logic signed [15:0] weight_v,
    input logic signed [15:0] weight_w,
    input logic        degenerate
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow the held output");

    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> !inside_res && weight_u == 16'sd0
            && weight_v == 16'sd0 && weight_w == 16'sd0)
        else $error("degenerate item with nonzero weights or coverage");

    a_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_res |-> !weight_u[15] && !weight_v[15])
        else $error("covered item with a negative weight");

endmodule

bind triangle_coverage_barycentric tcb_checker u_tcb_checker (.*);

`default_nettype wire
